/* hw/rtl/sequence_counter_table_assert.svh */
// Assertion macros shared by the sequence counter table RTL.
// Expects clk and rst in scope where a macro is used; no other dependencies.
`ifndef SEQUENCE_COUNTER_TABLE_ASSERT_SVH
`define SEQUENCE_COUNTER_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// Check on every rising edge, skipped while reset is high
`define SCT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sequence_counter_table: check failed");
// Check on every rising edge, reset included
`define SCT_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sequence_counter_table: check failed");
`else
`define SCT_ASSERT(label, prop)
`define SCT_ASSERT_ALWAYS(label, prop)
`endif

`endif

/* hw/rtl/sct_pkg.sv */
// Package for the sequence counter table: field widths, codes, FSM states and
// the controller/datapath command and status structs. No dependencies.
package sct_pkg;

  localparam int SLOTS_DEFAULT = 128;

  localparam int MODE_W     = 3;
  localparam int INDEX_W    = 9;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 7;
  localparam int VALUE_W    = 64;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DROP  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_NEXT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_CLEAR,
    ST_RESP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic scan;
    logic sweep;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_scan;
    logic is_clear;
    logic scan_done;
    logic sweep_last;
    logic out_free;
  } dp_stat_t;

endpackage

/* hw/rtl/sct_cmd_if.sv */
// Request channel of the sequence counter table: valid/ready plus item fields.
// Depends on sct_pkg for field widths.
interface sct_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [sct_pkg::MODE_W-1:0]        mode;
  logic signed [sct_pkg::INDEX_W-1:0] slot_index;

  modport source(output valid, output mode, output slot_index, input ready);
  modport sink(input valid, input mode, input slot_index, output ready);
endinterface

/* hw/rtl/sct_rsp_if.sv */
// Response channel of the sequence counter table: valid/ready plus result fields.
// Depends on sct_pkg for field widths.
interface sct_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [sct_pkg::STATUS_W-1:0]   status;
  logic [sct_pkg::SLOT_OUT_W-1:0] slot_out;
  logic [sct_pkg::VALUE_W-1:0]    value_out;

  modport source(output valid, output status, output slot_out, output value_out, input ready);
  modport sink(input valid, input status, input slot_out, input value_out, output ready);
endinterface

/* hw/rtl/sequence_counter_table.sv */
// Top level of the sequence counter table: controller plus datapath.
// Depends on sct_pkg, sct_cmd_if, sct_rsp_if, sct_ctrl, sct_datapath.
//
//   Channel  Role   Payload
//   cmd      sink   mode[2:0], slot_index[8:0] signed
//   rsp      source status[1:0], slot_out[6:0], value_out[63:0]
//
// Allocate with a never-used slot left, drop, read, next and unused modes pass
// through accept, execute and result hand-off to the output register.
// Allocate on a fully handed-out table scans one RAM entry per cycle, and
// clear-all zeroes one entry per cycle, both between execute and hand-off.
// After reset a sweep zeroes every RAM entry before the first accept.
// A stalled result holds in the output register and holds the next one back.
module sequence_counter_table #(
  parameter int SLOTS = sct_pkg::SLOTS_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  sct_cmd_if.sink   cmd,
  sct_rsp_if.source rsp
);

  sct_pkg::dp_cmd_t  ctl;
  sct_pkg::dp_stat_t stat;

  sct_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(cmd.valid),
    .in_ready(cmd.ready),
    .stat    (stat),
    .ctl     (ctl)
  );

  sct_datapath #(
    .SLOTS(SLOTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .in_mode      (cmd.mode),
    .in_slot_index(cmd.slot_index),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .out_status   (rsp.status),
    .out_slot     (rsp.slot_out),
    .out_value    (rsp.value_out)
  );

endmodule

/* hw/rtl/sct_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sct_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/sct_ctrl.sv */
// Controller FSM of the sequence counter table: sequences accept, execute,
// free-slot scan, clearing sweep and result hand-off. Depends on sct_pkg.
`include "sequence_counter_table_assert.svh"

module sct_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sct_pkg::dp_stat_t stat,
  output sct_pkg::dp_cmd_t  ctl
);

  sct_pkg::state_t state;
  sct_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sct_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    case (state)
      sct_pkg::ST_INIT: begin
        // zero the counter memory after reset
        ctl.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_next = sct_pkg::ST_IDLE;
        end
      end
      sct_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load_item = 1'b1;
          state_next    = sct_pkg::ST_EXEC;
        end
      end
      sct_pkg::ST_EXEC: begin
        ctl.exec = 1'b1;
        if (stat.need_scan) begin
          state_next = sct_pkg::ST_SCAN;
        end else if (stat.is_clear) begin
          state_next = sct_pkg::ST_CLEAR;
        end else begin
          state_next = sct_pkg::ST_RESP;
        end
      end
      sct_pkg::ST_SCAN: begin
        ctl.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = sct_pkg::ST_RESP;
        end
      end
      sct_pkg::ST_CLEAR: begin
        ctl.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_next = sct_pkg::ST_RESP;
        end
      end
      sct_pkg::ST_RESP: begin
        // hold the result until the output register is free
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = sct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sct_pkg::ST_INIT;
      end
    endcase
  end

  `SCT_ASSERT_ALWAYS(a_reset_enters_init, rst |=> state == sct_pkg::ST_INIT)

endmodule

/* hw/rtl/sct_datapath.sv */
// Datapath of the sequence counter table: counter RAM, high-water mark,
// scan/sweep counter, result and output registers. Depends on sct_pkg, sct_ram.
`include "sequence_counter_table_assert.svh"

module sct_datapath #(
  parameter int SLOTS = sct_pkg::SLOTS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sct_pkg::dp_cmd_t                    ctl,
  output sct_pkg::dp_stat_t                   stat,
  input  logic [sct_pkg::MODE_W-1:0]          in_mode,
  input  logic signed [sct_pkg::INDEX_W-1:0]  in_slot_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sct_pkg::STATUS_W-1:0]        out_status,
  output logic [sct_pkg::SLOT_OUT_W-1:0]      out_slot,
  output logic [sct_pkg::VALUE_W-1:0]         out_value
);

  localparam int AW   = $clog2(SLOTS);
  localparam int HWW  = $clog2(SLOTS + 1);
  localparam int IXW  = (AW > sct_pkg::INDEX_W - 1) ? AW : sct_pkg::INDEX_W - 1;
  localparam int SW   = (AW > sct_pkg::SLOT_OUT_W) ? AW : sct_pkg::SLOT_OUT_W;
  localparam int VW   = sct_pkg::VALUE_W;
  localparam logic [AW-1:0]  LAST_ADDR = AW'(SLOTS - 1);
  localparam logic [HWW-1:0] HW_FULL   = HWW'(SLOTS);
  localparam logic [IXW:0]   SLOTS_EXT = (IXW + 1)'(SLOTS);

  // Item and state registers
  logic [sct_pkg::MODE_W-1:0]  mode_q;
  logic [sct_pkg::INDEX_W-1:0] idx_q;
  logic [HWW-1:0]              hw, hw_next;
  logic [AW-1:0]               cnt, cnt_next;
  logic [sct_pkg::STATUS_W-1:0]   res_status, res_status_next;
  logic [sct_pkg::SLOT_OUT_W-1:0] res_slot, res_slot_next;
  logic [VW-1:0]                  res_value, res_value_next;

  // RAM ports
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [VW-1:0] wr_data;
  logic [AW-1:0] rd_addr;
  logic [VW-1:0] rd_data;

  // Decoded helpers
  logic [IXW-1:0] idx_wide;
  logic [AW-1:0]  idx_addr, in_addr, hw_addr;
  logic           idx_ok, hw_free, scan_hit, scan_last;
  logic [SW-1:0]  hw_slot_wide, cnt_slot_wide;
  logic [VW-1:0]  value_inc;

  sct_ram #(
    .WIDTH(VW),
    .DEPTH(SLOTS)
  ) u_counters (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Index decode: negative or past the table is out of range
  assign idx_wide  = IXW'(idx_q[sct_pkg::INDEX_W-2:0]);
  assign idx_addr  = idx_wide[AW-1:0];
  assign idx_ok    = !idx_q[sct_pkg::INDEX_W-1] && ({1'b0, idx_wide} < SLOTS_EXT);
  assign in_addr   = AW'(in_slot_index[sct_pkg::INDEX_W-2:0]);

  assign hw_free       = hw != HW_FULL;
  assign hw_addr       = hw[AW-1:0];
  assign hw_slot_wide  = SW'(hw_addr);
  assign cnt_slot_wide = SW'(cnt);
  assign scan_hit      = rd_data == '0;
  assign scan_last     = cnt == LAST_ADDR;
  assign value_inc     = rd_data + VW'(1);

  // Status to controller
  assign stat.need_scan  = (mode_q == sct_pkg::MODE_ALLOC) && !hw_free;
  assign stat.is_clear   = mode_q == sct_pkg::MODE_CLEAR;
  assign stat.scan_done  = scan_hit || scan_last;
  assign stat.sweep_last = cnt == LAST_ADDR;
  assign stat.out_free   = !out_valid || out_ready;

  // Operation logic
  always_comb begin
    wr_en           = 1'b0;
    wr_addr         = cnt;
    wr_data         = '0;
    rd_addr         = cnt;
    hw_next         = hw;
    cnt_next        = cnt;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    res_value_next  = res_value;

    if (ctl.load_item) begin
      // fetch the addressed counter for the execute cycle
      rd_addr = in_addr;
    end

    if (ctl.exec) begin
      res_status_next = sct_pkg::STATUS_OK;
      res_slot_next   = '0;
      res_value_next  = '0;
      case (mode_q)
        sct_pkg::MODE_ALLOC: begin
          if (hw_free) begin
            wr_en          = 1'b1;
            wr_addr        = hw_addr;
            wr_data        = VW'(1);
            res_slot_next  = hw_slot_wide[sct_pkg::SLOT_OUT_W-1:0];
            res_value_next = VW'(1);
            hw_next        = hw + HWW'(1);
          end else begin
            // start the free-slot scan at entry zero
            rd_addr  = '0;
            cnt_next = '0;
          end
        end
        sct_pkg::MODE_DROP: begin
          if (idx_ok) begin
            wr_en   = 1'b1;
            wr_addr = idx_addr;
            wr_data = '0;
          end else begin
            res_status_next = sct_pkg::STATUS_RANGE;
          end
        end
        sct_pkg::MODE_READ: begin
          if (idx_ok) begin
            res_value_next = rd_data;
          end else begin
            res_status_next = sct_pkg::STATUS_RANGE;
          end
        end
        sct_pkg::MODE_NEXT: begin
          if (idx_ok) begin
            wr_en          = 1'b1;
            wr_addr        = idx_addr;
            wr_data        = value_inc;
            res_value_next = value_inc;
          end else begin
            res_status_next = sct_pkg::STATUS_RANGE;
          end
        end
        sct_pkg::MODE_CLEAR: begin
          hw_next  = '0;
          cnt_next = '0;
        end
        default: begin
        end
      endcase
    end

    if (ctl.scan) begin
      // rd_data holds the counter at cnt; next address is already issued
      if (scan_hit) begin
        wr_en           = 1'b1;
        wr_addr         = cnt;
        wr_data         = VW'(1);
        res_status_next = sct_pkg::STATUS_OK;
        res_slot_next   = cnt_slot_wide[sct_pkg::SLOT_OUT_W-1:0];
        res_value_next  = VW'(1);
      end else if (scan_last) begin
        res_status_next = sct_pkg::STATUS_FULL;
        res_slot_next   = '0;
        res_value_next  = '0;
      end else begin
        cnt_next = cnt + AW'(1);
        rd_addr  = cnt + AW'(1);
      end
    end

    if (ctl.sweep) begin
      wr_en    = 1'b1;
      wr_addr  = cnt;
      wr_data  = '0;
      cnt_next = cnt + AW'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hw        <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      hw  <= hw_next;
      cnt <= cnt_next;
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      mode_q <= in_mode;
      idx_q  <= in_slot_index;
    end
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    res_value  <= res_value_next;
    if (ctl.out_load) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_value  <= res_value;
    end
  end

  `SCT_ASSERT(a_no_result_overwrite, ctl.out_load |-> (!out_valid || out_ready))
  `SCT_ASSERT(a_high_water_bounded, hw <= HW_FULL)
  `SCT_ASSERT(a_scan_only_when_full, ctl.scan |-> (hw == HW_FULL))

endmodule
